@@ src/tcs_pkg.sv @@
// tcs_pkg: shared types, constants and codes of the texture color sampler
// used by tcs_front, tcs_back and the core; depends on nothing
package tcs_pkg;

   localparam int MAX_SIDE    = 256;
   localparam int TEXEL_DEPTH = 65536;
   localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
   localparam int SIDE_W      = 9;
   localparam int IDX_W       = $clog2(MAX_SIDE);
   localparam int COORD_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int UNIT_W      = FRAC_W + 1;
   localparam int RGB_W       = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_AXES    = 3;

   // 1/pi with 64 fraction bits
   localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;
   localparam logic [UNIT_W-1:0] ONE_Q16 = UNIT_W'(1 << FRAC_W);
   localparam logic [RGB_W-1:0] RGB_GREEN = 24'h00FF00;
   localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ODD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EVEN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT = 3'd6;

   // mode register codes
   localparam logic [1:0] MODE_SOLID   = 2'd0;
   localparam logic [1:0] MODE_CHECKER = 2'd1;
   localparam logic [1:0] MODE_IMAGE   = 2'd2;
   localparam logic [1:0] MODE_BLACK   = 2'd3;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_SOLID,
      KIND_CHECKER,
      KIND_IMAGE,
      KIND_GREEN,
      KIND_BLACK
   } kind_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [RGB_W-1:0]  solid_rgb;
      logic [RGB_W-1:0]  odd_rgb;
      logic [RGB_W-1:0]  even_rgb;
      logic [SIDE_W-1:0] width;   // saturated to 1..MAX_SIDE
      logic [SIDE_W-1:0] height;  // saturated to 1..MAX_SIDE
      logic              present;
   } cfg_type;

   // one classified item as it waits between front and back
   typedef struct packed {
      kind_type                          kind;
      logic [UNIT_W-1:0]                 u;
      logic [UNIT_W-1:0]                 v;
      logic [NUM_AXES-1:0][COORD_W-1:0]  mag;
      logic [NUM_AXES-1:0]               sgn;
      logic                              any_zero;
      logic [TEXEL_AW-1:0]               texel_addr;
      logic [RGB_W-1:0]                  texel_rgb;
   } work_type;

endpackage

@@ src/tcs_ram.sv @@
// tcs_ram: generic single write port, single read port ram, registered read
// no dependencies
module tcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tcs_fifo.sv @@
// tcs_fifo: small register fifo, head shown combinationally, DEPTH >= 2
// no dependencies
module tcs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("fifo written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("fifo read while empty");

endmodule

@@ src/tcs_front.sv @@
// tcs_front: accepts requests, classifies them by command and mode and
// prepares coordinates; depends on tcs_pkg and tcs_fifo
module tcs_front
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   input  logic signed [COORD_W-1:0] req_px,
   input  logic signed [COORD_W-1:0] req_py,
   input  logic signed [COORD_W-1:0] req_pz,
   input  logic [TEXEL_AW-1:0]       req_texel_addr,
   input  logic [RGB_W-1:0]          req_texel_rgb,
   input  logic                      q_pop,
   output logic                      q_valid,
   output work_type                  q_data
);

   localparam int WORK_W = $bits(work_type);

   work_type          item;
   logic              q_full;
   logic              push;
   logic [WORK_W-1:0] head_raw;
   logic [NUM_AXES-1:0][COORD_W-1:0] coord;

   // clamp a signed Q16.16 value to [0, 1.0]
   function automatic logic [UNIT_W-1:0] clamp_unit(input logic [COORD_W-1:0] c);
      logic [UNIT_W-1:0] r;
      if (c[COORD_W-1]) begin
         r = '0;
      end else if (c > COORD_W'(ONE_Q16)) begin
         r = ONE_Q16;
      end else begin
         r = c[UNIT_W-1:0];
      end
      return r;
   endfunction

   assign coord[0] = req_px;
   assign coord[1] = req_py;
   assign coord[2] = req_pz;

   always_comb begin
      item            = '0;
      item.texel_addr = req_texel_addr;
      item.texel_rgb  = req_texel_rgb;
      item.u          = clamp_unit(req_u_coord);
      item.v          = ONE_Q16 - clamp_unit(req_v_coord);
      item.any_zero   = 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
         item.sgn[k] = coord[k][COORD_W-1];
         item.mag[k] = coord[k][COORD_W-1] ? (~coord[k] + COORD_W'(1)) : coord[k];
         if (coord[k] == '0) begin
            item.any_zero = 1'b1;
         end
      end
      if (req_command == CMD_LOAD) begin
         item.kind = KIND_LOAD;
      end else begin
         unique case (cfg.mode)
            MODE_SOLID:   item.kind = KIND_SOLID;
            MODE_CHECKER: item.kind = KIND_CHECKER;
            MODE_IMAGE:   item.kind = cfg.present ? KIND_IMAGE : KIND_GREEN;
            default:      item.kind = KIND_BLACK;
         endcase
      end
   end

   assign push      = req_valid && !q_full;
   assign req_stall = q_full;

   tcs_fifo #(
      .WIDTH (WORK_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (item),
      .pop       (q_pop),
      .pop_data  (head_raw),
      .not_empty (q_valid),
      .full      (q_full)
   );

   assign q_data = work_type'(head_raw);

endmodule

@@ src/tcs_back.sv @@
// tcs_back: executes classified items: checker parity, image lookup, texel
// store and result fifo; depends on tcs_pkg, tcs_ram and tcs_fifo
module tcs_back
   import tcs_pkg::*;
#(
   parameter int RESULT_DEPTH = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           q_valid,
   input  work_type       q_data,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_red,
   output logic [7:0]     rsp_green,
   output logic [7:0]     rsp_blue
);

   localparam int CRED_W  = $clog2(RESULT_DEPTH + 1);
   localparam int PROD_W  = UNIT_W + SIDE_W;
   localparam int RAW_W   = PROD_W - FRAC_W;
   localparam int SUM_W   = IDX_W + SIDE_W + 1;
   localparam int PAR_BIT = 80;           // parity of floor(10*mag/pi)
   localparam int KEEP_W  = PAR_BIT + 1;
   localparam int TEN_W   = KEEP_W + 3;

   // credits for results in flight or waiting in the result fifo
   logic [CRED_W-1:0] credit_ff, credit_in;
   logic              rsp_xfer;
   logic              res_full;
   logic              res_push;
   logic [RGB_W-1:0]  res_rgb;
   logic [RGB_W-1:0]  head_rgb;

   // stage 1
   logic     s1_valid_ff;
   work_type s1_ff;
   logic [NUM_AXES-1:0][63:0] plo, phi;
   logic [PROD_W-1:0] i_prod, j_prod;
   logic [RAW_W-1:0]  i_raw, j_raw;
   logic [IDX_W-1:0]  i_idx, j_idx;

   // stage 2
   logic                      s2_valid_ff;
   kind_type                  s2_kind_ff;
   logic [NUM_AXES-1:0][63:0] s2_plo_ff, s2_phi_ff;
   logic [NUM_AXES-1:0]       s2_sgn_ff;
   logic                      s2_zero_ff;
   logic [IDX_W-1:0]          s2_i_ff, s2_j_ff;
   logic [TEXEL_AW-1:0]       s2_taddr_ff;
   logic [RGB_W-1:0]          s2_trgb_ff;
   logic [NUM_AXES-1:0][95:0] prod;
   logic [SUM_W-1:0]          addr_sum;
   logic                      ram_we;
   logic [RGB_W-1:0]          ram_rdata;

   // stage 3
   logic                          s3_valid_ff;
   kind_type                      s3_kind_ff;
   logic [NUM_AXES-1:0][KEEP_W-1:0] s3_p_ff;
   logic [NUM_AXES-1:0]           s3_sgn_ff;
   logic                          s3_zero_ff;
   logic [TEN_W-1:0]              ten;
   logic [NUM_AXES-1:0]           neg;
   logic                          odd;

   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign q_pop     = q_valid && (credit_ff < CRED_W'(RESULT_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (q_pop && (q_data.kind != KIND_LOAD)) begin
         credit_in = credit_in + CRED_W'(1);
      end
      if (rsp_xfer) begin
         credit_in = credit_in - CRED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: partial products of mag * (1/pi), texel column and row
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         plo[k] = 64'(s1_ff.mag[k]) * 64'(INV_PI_Q64[31:0]);
         phi[k] = 64'(s1_ff.mag[k]) * 64'(INV_PI_Q64[63:32]);
      end
      i_prod = PROD_W'(s1_ff.u) * PROD_W'(cfg.width);
      j_prod = PROD_W'(s1_ff.v) * PROD_W'(cfg.height);
      i_raw  = i_prod[PROD_W-1:FRAC_W];
      j_raw  = j_prod[PROD_W-1:FRAC_W];
      i_idx  = (i_raw >= RAW_W'(cfg.width)) ? IDX_W'(cfg.width - SIDE_W'(1))
                                             : IDX_W'(i_raw);
      j_idx  = (j_raw >= RAW_W'(cfg.height)) ? IDX_W'(cfg.height - SIDE_W'(1))
                                              : IDX_W'(j_raw);
   end

   always_ff @(posedge clock) begin
      s1_ff       <= q_data;
      s2_kind_ff  <= s1_ff.kind;
      s2_plo_ff   <= plo;
      s2_phi_ff   <= phi;
      s2_sgn_ff   <= s1_ff.sgn;
      s2_zero_ff  <= s1_ff.any_zero;
      s2_i_ff     <= i_idx;
      s2_j_ff     <= j_idx;
      s2_taddr_ff <= s1_ff.texel_addr;
      s2_trgb_ff  <= s1_ff.texel_rgb;
   end

   // stage 2: full products, texel address, store access
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         prod[k] = {s2_phi_ff[k], 32'b0} + {32'b0, s2_plo_ff[k]};
      end
      addr_sum = SUM_W'(s2_j_ff) * SUM_W'(cfg.width) + SUM_W'(s2_i_ff);
   end

   assign ram_we = s2_valid_ff && (s2_kind_ff == KIND_LOAD);

   tcs_ram #(
      .WIDTH (RGB_W),
      .DEPTH (TEXEL_DEPTH)
   ) u_texels (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_taddr_ff),
      .wr_data (s2_trgb_ff),
      .rd_addr (addr_sum[TEXEL_AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      s3_kind_ff <= s2_kind_ff;
      s3_sgn_ff  <= s2_sgn_ff;
      s3_zero_ff <= s2_zero_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         s3_p_ff[k] <= prod[k][KEEP_W-1:0];
      end
   end

   // stage 3: times ten, parity, color select
   always_comb begin
      ten = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         ten    = (TEN_W'(s3_p_ff[k]) << 3) + (TEN_W'(s3_p_ff[k]) << 1);
         neg[k] = ten[PAR_BIT] ^ s3_sgn_ff[k];
      end
      odd = !s3_zero_ff && (^neg);
      unique case (s3_kind_ff)
         KIND_SOLID:   res_rgb = cfg.solid_rgb;
         KIND_CHECKER: res_rgb = odd ? cfg.odd_rgb : cfg.even_rgb;
         KIND_IMAGE:   res_rgb = ram_rdata;
         KIND_GREEN:   res_rgb = RGB_GREEN;
         default:      res_rgb = RGB_BLACK;
      endcase
   end

   assign res_push = s3_valid_ff && (s3_kind_ff != KIND_LOAD);

   tcs_fifo #(
      .WIDTH (RGB_W),
      .DEPTH (RESULT_DEPTH)
   ) u_results (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_rgb),
      .pop       (rsp_xfer),
      .pop_data  (head_rgb),
      .not_empty (rsp_valid),
      .full      (res_full)
   );

   assign rsp_red   = head_rgb[23:16];
   assign rsp_green = head_rgb[15:8];
   assign rsp_blue  = head_rgb[7:0];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRED_W'(RESULT_DEPTH))
      else $error("result credits exceed fifo depth");

   a_credit_covers: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid || res_push) |-> (credit_ff != '0))
      else $error("result present with no credit held");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full || rsp_xfer)
      else $error("result pushed into full fifo");

endmodule

@@ src/texture_color_sampler_core.sv @@
// texture_color_sampler_core: top level, config registers, front and back
// depends on tcs_pkg, tcs_front, tcs_back (and below them tcs_fifo, tcs_ram)
//
//  port group | dir | handshake          | payload
//  req_*      | in  | req_valid/stall    | command, u/v coord, px/py/pz, texel addr/rgb
//  rsp_*      | out | rsp_valid/stall    | red, green, blue
//  csr_*      | in  | csr_write          | csr_index, csr_data (24 bits)
//
// one item accepted per cycle while req_stall is low; a sample's result goes from the
// front queue through three back stages into the result fifo
// a load writes the store from the second back stage
// reset empties the queue and the result fifo; the texel store holds no reset value
// req_stall rises only when the front queue is full; the back keeps credits for the
// result fifo, so the pipeline never stalls mid-flight and rsp_stall backs up the queue
module texture_color_sampler_core
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 4,
   parameter int RESULT_DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   input  logic signed [COORD_W-1:0] req_px,
   input  logic signed [COORD_W-1:0] req_py,
   input  logic signed [COORD_W-1:0] req_pz,
   input  logic [TEXEL_AW-1:0]       req_texel_addr,
   input  logic [RGB_W-1:0]          req_texel_rgb,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [RGB_W-1:0]          csr_data
);

   logic [1:0]        mode_ff;
   logic [RGB_W-1:0]  solid_ff;
   logic [RGB_W-1:0]  odd_ff;
   logic [RGB_W-1:0]  even_ff;
   logic [SIDE_W-1:0] width_ff;
   logic [SIDE_W-1:0] height_ff;
   logic              present_ff;
   cfg_type           cfg;
   logic              q_valid;
   logic              q_pop;
   work_type          q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SOLID;
         solid_ff   <= '0;
         odd_ff     <= '0;
         even_ff    <= '1;
         width_ff   <= SIDE_W'(1);
         height_ff  <= SIDE_W'(1);
         present_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_data[1:0];
            CSR_SOLID:   solid_ff   <= csr_data;
            CSR_ODD:     odd_ff     <= csr_data;
            CSR_EVEN:    even_ff    <= csr_data;
            CSR_WIDTH:   width_ff   <= csr_data[SIDE_W-1:0];
            CSR_HEIGHT:  height_ff  <= csr_data[SIDE_W-1:0];
            CSR_PRESENT: present_ff <= csr_data[0];
            default:     ;
         endcase
      end
   end

   // sides saturate to 1..MAX_SIDE
   always_comb begin
      cfg.mode      = mode_ff;
      cfg.solid_rgb = solid_ff;
      cfg.odd_rgb   = odd_ff;
      cfg.even_rgb  = even_ff;
      cfg.present   = present_ff;
      if (width_ff == '0) begin
         cfg.width = SIDE_W'(1);
      end else if (width_ff > SIDE_W'(MAX_SIDE)) begin
         cfg.width = SIDE_W'(MAX_SIDE);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = SIDE_W'(1);
      end else if (height_ff > SIDE_W'(MAX_SIDE)) begin
         cfg.height = SIDE_W'(MAX_SIDE);
      end else begin
         cfg.height = height_ff;
      end
   end

   tcs_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_u_coord    (req_u_coord),
      .req_v_coord    (req_v_coord),
      .req_px         (req_px),
      .req_py         (req_py),
      .req_pz         (req_pz),
      .req_texel_addr (req_texel_addr),
      .req_texel_rgb  (req_texel_rgb),
      .q_pop          (q_pop),
      .q_valid        (q_valid),
      .q_data         (q_data)
   );

   tcs_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule
